FILE: src/bpdh_pkg.sv
// Shared types and constants for the peak-hold decimation to hue block.
`default_nettype none
package bpdh_pkg;

  // Longest scan column; the sample with index MAX_SCAN_LEN-1 closes it.
  localparam int MAX_SCAN_LEN = 255;

  // Pixel job queue between the sample front end and the hue unit.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [7:0] REG_DECIMATE_ON = 8'd0;
  localparam logic [7:0] REG_BIN_STEP    = 8'd1;
  localparam logic [7:0] REG_ROW_LIMIT   = 8'd2;
  localparam logic [7:0] REG_THRESHOLD   = 8'd3;

  localparam logic [16:0] BOUNDARY_MAX = 17'h1FFFF;
  localparam logic [7:0]  ROW_SAT      = 8'd255;
  localparam logic [8:0]  HUE_FLAT     = 9'd255;
  localparam logic [8:0]  HUE_FULL     = 9'd256;

  // Divider runs one quotient bit per cycle over a 16-bit numerator.
  localparam int DIV_BITS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] peak;
    logic       col_end;
  } job_t;

  // Up to two pixel jobs handed to the queue in one transfer, in order.
  typedef struct packed {
    logic [1:0] n;
    job_t       a;
    job_t       b;
  } push_t;

endpackage
`default_nettype wire

FILE: src/bpdh_front.sv
// Front end: tracks bins and peaks per sample and produces pixel jobs.
`default_nettype none
module bpdh_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              decimate_on,
  input  wire logic [15:0]       bin_step,
  input  wire logic [7:0]        row_limit,
  input  wire logic              accept,
  input  wire logic [7:0]        sample,
  input  wire logic              last_sample,
  output bpdh_pkg::push_t        push
);

  logic        bin_open;
  logic [7:0]  sample_count;
  logic [16:0] bin_boundary;
  logic [7:0]  running_peak;
  logic [7:0]  row_count;

  logic [7:0]  sc_eff;
  logic [16:0] bnd_eff;
  logic [7:0]  pk_eff;
  logic [7:0]  rc_eff;
  logic        is_last;
  logic        in_bin;
  logic        closing;
  logic [17:0] bnd_sum;
  logic [16:0] bnd_adv;
  logic [7:0]  rc_new;
  logic [7:0]  pk_new;
  logic        emit1;
  logic        emit2;

  always_comb begin
    // A column starts fresh on its first sample.
    sc_eff  = bin_open ? sample_count : 8'd0;
    bnd_eff = bin_open ? bin_boundary : {1'b0, bin_step};
    pk_eff  = bin_open ? running_peak : 8'd0;
    rc_eff  = bin_open ? row_count : 8'd0;
    is_last = last_sample || (sc_eff >= 8'(bpdh_pkg::MAX_SCAN_LEN - 1));

    in_bin  = {1'b0, sc_eff, 8'h00} < bnd_eff;
    closing = decimate_on && !in_bin;
    bnd_sum = {1'b0, bnd_eff} + {2'b00, bin_step};
    bnd_adv = bnd_sum[17] ? bpdh_pkg::BOUNDARY_MAX : bnd_sum[16:0];

    rc_new = (closing && rc_eff != bpdh_pkg::ROW_SAT) ? rc_eff + 8'd1 : rc_eff;
    if (decimate_on && in_bin) begin
      pk_new = (sample > pk_eff) ? sample : pk_eff;
    end else begin
      pk_new = sample;
    end

    emit1 = closing && (rc_eff < row_limit);
    emit2 = decimate_on && is_last && (rc_new < row_limit);

    push.b = '{row: rc_new, peak: pk_new, col_end: is_last};
    if (!decimate_on) begin
      push.n = 2'd1;
      push.a = '{row: sc_eff, peak: sample, col_end: is_last};
    end else begin
      push.n = {1'b0, emit1} + {1'b0, emit2};
      if (emit1) begin
        push.a = '{row: rc_eff, peak: pk_eff, col_end: is_last && !emit2};
      end else begin
        push.a = '{row: rc_new, peak: pk_new, col_end: is_last};
      end
    end
    if (!accept) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_open     <= 1'b0;
      sample_count <= 8'd0;
      bin_boundary <= 17'd0;
      running_peak <= 8'd0;
      row_count    <= 8'd0;
    end else if (accept) begin
      bin_open     <= !is_last;
      sample_count <= is_last ? 8'd0 : sc_eff + 8'd1;
      bin_boundary <= closing ? bnd_adv : bnd_eff;
      running_peak <= pk_new;
      row_count    <= rc_new;
    end
  end

endmodule
`default_nettype wire

FILE: src/bpdh_queue.sv
// Small pixel job queue that takes up to two jobs and gives one per cycle when popped.
`default_nettype none
module bpdh_queue (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bpdh_pkg::push_t              push,
  output logic                              room,
  input  wire logic                         pop,
  output logic                              head_valid,
  output bpdh_pkg::job_t                    head,
  output logic [bpdh_pkg::QCNT_W-1:0]       count
);

  bpdh_pkg::job_t                mem [bpdh_pkg::QUEUE_DEPTH];
  logic [bpdh_pkg::QPTR_W-1:0]   wr_ptr;
  logic [bpdh_pkg::QPTR_W-1:0]   rd_ptr;
  logic [bpdh_pkg::QPTR_W-1:0]   wr_ptr_next;
  logic                          do_pop;

  assign room       = count <= bpdh_pkg::QCNT_W'(bpdh_pkg::QUEUE_DEPTH - 2);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;
  assign wr_ptr_next = wr_ptr + bpdh_pkg::QPTR_W'(1);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.a;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_next] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + bpdh_pkg::QPTR_W'(push.n);
      if (do_pop) begin
        rd_ptr <= rd_ptr + bpdh_pkg::QPTR_W'(1);
      end
      count <= count + bpdh_pkg::QCNT_W'(push.n) - bpdh_pkg::QCNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

FILE: src/bpdh_hue.sv
// Back end: turns a pixel job into a hue level with a bit-serial divider.
`default_nettype none
module bpdh_hue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        threshold,
  input  wire logic              job_valid,
  input  wire bpdh_pkg::job_t    job,
  output logic                   job_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_row,
  output logic [8:0]             out_hue,
  output logic                   out_end
);

  typedef enum logic [1:0] {IDLE, DIVIDE, FINISH} state_t;

  state_t                          state;
  logic [7:0]                      row;
  logic                            col_end;
  logic [15:0]                     num;
  logic [7:0]                      rem;
  logic [bpdh_pkg::DIV_CNT_W-1:0]  cnt;

  logic [15:0] numer;
  logic [8:0]  rem_sh;
  logic        q_bit;
  logic [8:0]  hue;
  logic        out_free;

  always_comb begin
    // Ceiling of 255*peak/threshold: numerator is 255*peak + threshold - 1.
    numer  = {job.peak, 8'h00} - {8'd0, job.peak} + {8'd0, threshold} - 16'd1;
    rem_sh = {rem, num[15]};
    q_bit  = rem_sh >= {1'b0, threshold};
    if (threshold == 8'd0) begin
      hue = bpdh_pkg::HUE_FLAT;
    end else if (num[15:8] != 8'd0) begin
      hue = 9'd0;
    end else begin
      hue = bpdh_pkg::HUE_FULL - {1'b0, num[7:0]};
    end
    out_free = !out_valid || out_ready;
  end

  assign job_pop = (state == IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (job_valid) begin
            row     <= job.row;
            col_end <= job.col_end;
            num     <= numer;
            rem     <= 8'd0;
            cnt     <= bpdh_pkg::DIV_CNT_W'(bpdh_pkg::DIV_BITS - 1);
            state   <= DIVIDE;
          end
        end
        DIVIDE: begin
          rem <= q_bit ? 8'(rem_sh - {1'b0, threshold}) : rem_sh[7:0];
          num <= {num[14:0], q_bit};
          cnt <= cnt - bpdh_pkg::DIV_CNT_W'(1);
          if (cnt == '0) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            out_row   <= row;
            out_hue   <= hue;
            out_end   <= col_end;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/bscan_peak_decimate_to_hue_unit.sv
// Top level of the scan column peak-hold decimation to hue block.
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         s_tvalid/s_tready  tdata[7:0] sample, tlast last_sample
//   m_*      out        m_tvalid/m_tready  tdata[7:0] row_index, [16:8] hue_level,
//                                          tlast column_end
//   cfg_*    in         cfg_valid/cfg_ready index 0..3, data (low bits used)
//
// The front end takes one sample per cycle while the job queue has two free slots.
// Each pixel then passes the hue unit's load, bit-serial divide and output states;
// no new pixel enters before the last is out, which sets the sustained pixel rate.
// Reset is synchronous; it clears the column state, the queue and the output.
// A stalled output holds the hue unit, which then backs up the queue and s_tready.
`default_nettype none
module bscan_peak_decimate_to_hue_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] sample
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] row_index, [16:8] hue_level, zero fill
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic        decimate_on;
  logic [15:0] bin_step;
  logic [7:0]  row_limit;
  logic [7:0]  threshold;

  bpdh_pkg::push_t              push;
  bpdh_pkg::job_t               head;
  logic                         head_valid;
  logic                         room;
  logic                         job_pop;
  logic [bpdh_pkg::QCNT_W-1:0]  q_count;
  logic [7:0]                   out_row;
  logic [8:0]                   out_hue;

  assign cfg_ready = 1'b1;
  assign s_tready  = room;
  assign m_tdata   = {7'd0, out_hue, out_row};

  always_ff @(posedge clk) begin
    if (rst) begin
      decimate_on <= 1'b0;
      bin_step    <= 16'd256;
      row_limit   <= 8'd255;
      threshold   <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpdh_pkg::REG_DECIMATE_ON: decimate_on <= cfg_data[0];
        bpdh_pkg::REG_BIN_STEP:    bin_step    <= cfg_data;
        bpdh_pkg::REG_ROW_LIMIT:   row_limit   <= cfg_data[7:0];
        bpdh_pkg::REG_THRESHOLD:   threshold   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  bpdh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .decimate_on (decimate_on),
    .bin_step    (bin_step),
    .row_limit   (row_limit),
    .accept      (s_tvalid && s_tready),
    .sample      (s_tdata),
    .last_sample (s_tlast),
    .push        (push)
  );

  bpdh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  bpdh_hue u_hue (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .job_valid (head_valid),
    .job       (head),
    .job_pop   (job_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_row   (out_row),
    .out_hue   (out_hue),
    .out_end   (m_tlast)
  );

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= bpdh_pkg::QCNT_W'(bpdh_pkg::QUEUE_DEPTH))
    else $error("job queue overflow");

  a_ready_means_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> q_count <= bpdh_pkg::QCNT_W'(bpdh_pkg::QUEUE_DEPTH - 2))
    else $error("sample taken without room for two jobs");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[16:8] <= bpdh_pkg::HUE_FULL)
    else $error("hue level out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/bscan_peak_decimate_to_hue_unit_test.sv
// Self-checking testbench for the scan column peak-hold decimation to hue block.
module bscan_peak_decimate_to_hue_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  // Cycles for the job queue and the hue unit to empty out after the last pixel.
  localparam int SETTLE = 200;

  typedef struct {
    logic [7:0] row;
    logic [8:0] hue;
    logic       col_end;
  } pixel_t;

  typedef struct {
    logic        is_cfg;
    logic [7:0]  idx;
    logic [15:0] val;
    logic [7:0]  smp;
    logic        mark;
    logic        typed;
    pixel_t      want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] sample
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [7:0] row_index, [16:8] hue_level, zero fill
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bscan_peak_decimate_to_hue_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Register copies and column state of the predictor.
  logic        cfg_decimate = 1'b0;
  logic [15:0] cfg_step = 16'd256;
  logic [7:0]  cfg_limit = 8'd255;
  logic [7:0]  cfg_thresh = 8'd0;
  logic        col_open = 1'b0;
  logic [7:0]  smp_cnt = '0;
  logic [16:0] boundary = '0;
  logic [7:0]  peak = '0;
  logic [7:0]  rows = '0;

  pixel_t   pending_pixels[$];
  dir_row_t directed[$];
  pixel_t   want_px;
  int       mismatches = 0;
  int       cycle_count = 0;
  int       send_idle = 0;
  int       recv_idle = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [8:0] hue_for(input logic [7:0] level);
    int q;
    if (cfg_thresh == 0) return bpdh_pkg::HUE_FLAT;
    q = (255 * int'(level) + int'(cfg_thresh) - 1) / int'(cfg_thresh);
    return (q >= 256) ? 9'd0 : 9'(256 - q);
  endfunction

  function automatic pixel_t make_pixel(input logic [7:0] row, input logic [7:0] level);
    pixel_t p;
    p.row = row;
    p.hue = hue_for(level);
    p.col_end = 1'b0;
    return p;
  endfunction

  // Advances the column state by one sample and returns the pixels it releases.
  function automatic int column_pixels(input logic [7:0] smp, input logic mark,
                                       output pixel_t p0, output pixel_t p1);
    int n;
    logic fin;
    logic [17:0] nxt;
    n = 0;
    fin = mark;
    p0 = make_pixel(8'd0, 8'd0);
    p1 = p0;
    if (!col_open) begin
      col_open = 1'b1;
      smp_cnt = '0;
      boundary = {1'b0, cfg_step};
      peak = '0;
      rows = '0;
    end
    if (smp_cnt >= 8'(bpdh_pkg::MAX_SCAN_LEN - 1)) fin = 1'b1;
    if (cfg_decimate) begin
      if ({smp_cnt, 8'h00} < boundary) begin
        if (smp > peak) peak = smp;
      end else begin
        if (rows < cfg_limit) begin
          p0 = make_pixel(rows, peak);
          n = 1;
        end
        if (rows < bpdh_pkg::ROW_SAT) rows = rows + 8'd1;
        nxt = {1'b0, boundary} + 18'(cfg_step);
        boundary = (nxt > 18'(bpdh_pkg::BOUNDARY_MAX)) ? bpdh_pkg::BOUNDARY_MAX
                                                        : nxt[16:0];
        peak = smp;
      end
      // The bin still open at the end of the column is flushed too.
      if (fin && rows < cfg_limit) begin
        if (n == 0) p0 = make_pixel(rows, peak);
        else p1 = make_pixel(rows, peak);
        n = n + 1;
      end
    end else begin
      peak = smp;
      p0 = make_pixel(smp_cnt, smp);
      n = 1;
    end
    if (fin) begin
      if (n == 1) p0.col_end = 1'b1;
      else if (n == 2) p1.col_end = 1'b1;
      col_open = 1'b0;
      smp_cnt = '0;
    end else begin
      smp_cnt = smp_cnt + 8'd1;
    end
    return n;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input logic [7:0] smp, input logic mark, input logic typed,
                             input pixel_t want);
    pixel_t p0, p1;
    int n;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    s_tlast <= mark;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = column_pixels(smp, mark, p0, p1);
    if (typed) begin
      pending_pixels.push_back(want);
    end else begin
      if (n > 0) pending_pixels.push_back(p0);
      if (n > 1) pending_pixels.push_back(p1);
    end
    @(negedge clk);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bpdh_pkg::REG_DECIMATE_ON: cfg_decimate = val[0];
      bpdh_pkg::REG_BIN_STEP:    cfg_step = val;
      bpdh_pkg::REG_ROW_LIMIT:   cfg_limit = val[7:0];
      bpdh_pkg::REG_THRESHOLD:   cfg_thresh = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void dir_cfg(input logic [7:0] idx, input logic [15:0] val);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    r.smp = '0;
    r.mark = 1'b0;
    r.typed = 1'b0;
    r.want = make_pixel(8'd0, 8'd0);
    directed.push_back(r);
  endfunction

  function automatic void dir_smp(input logic [7:0] smp, input logic mark);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.idx = '0;
    r.val = '0;
    r.smp = smp;
    r.mark = mark;
    r.typed = 1'b0;
    r.want = make_pixel(8'd0, 8'd0);
    directed.push_back(r);
  endfunction

  function automatic void dir_chk(input logic [7:0] smp, input logic mark,
                                  input logic [7:0] row, input logic [8:0] hue,
                                  input logic col_end);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.idx = '0;
    r.val = '0;
    r.smp = smp;
    r.mark = mark;
    r.typed = 1'b1;
    r.want.row = row;
    r.want.hue = hue;
    r.want.col_end = col_end;
    directed.push_back(r);
  endfunction

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel row %0d hue %0d end %0b", $time,
                 m_tdata[7:0], m_tdata[16:8], m_tlast);
        mismatches++;
      end else begin
        want_px = pending_pixels.pop_front();
        if (m_tdata[7:0] !== want_px.row) begin
          $display("%0t: row_index expected %0d actual %0d", $time, want_px.row,
                   m_tdata[7:0]);
          mismatches++;
        end
        if (m_tdata[16:8] !== want_px.hue) begin
          $display("%0t: hue_level expected %0d actual %0d", $time, want_px.hue,
                   m_tdata[16:8]);
          mismatches++;
        end
        if (m_tlast !== want_px.col_end) begin
          $display("%0t: column_end expected %0b actual %0b", $time, want_px.col_end,
                   m_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int mode, ph, phase_no, k, n_items, col_left;
    logic col_marked, force_long;
    logic [7:0] smp;
    logic [15:0] step_val, limit_val, thresh_val, dec_val;
    col_left = 0;
    col_marked = 1'b0;
    force_long = 1'b0;

    // Pass-through with a zero threshold gives the flat hue; then the hue extremes.
    dir_chk(8'd0, 1'b1, 8'd0, bpdh_pkg::HUE_FLAT, 1'b1);
    dir_chk(8'd255, 1'b1, 8'd0, bpdh_pkg::HUE_FLAT, 1'b1);
    dir_cfg(bpdh_pkg::REG_THRESHOLD, 16'd255);
    dir_chk(8'd255, 1'b1, 8'd0, 9'd1, 1'b1);
    dir_chk(8'd0, 1'b1, 8'd0, bpdh_pkg::HUE_FULL, 1'b1);
    dir_cfg(bpdh_pkg::REG_THRESHOLD, 16'd1);
    dir_chk(8'd2, 1'b0, 8'd0, 9'd0, 1'b0);
    dir_chk(8'd1, 1'b1, 8'd1, 9'd1, 1'b1);
    // Decimation with one sample per bin, then one bin over the whole column.
    dir_cfg(bpdh_pkg::REG_THRESHOLD, 16'd100);
    dir_cfg(bpdh_pkg::REG_DECIMATE_ON, 16'd1);
    dir_smp(8'd10, 1'b0);
    dir_smp(8'd200, 1'b0);
    dir_smp(8'd30, 1'b0);
    dir_smp(8'd5, 1'b1);
    dir_cfg(bpdh_pkg::REG_BIN_STEP, 16'hFFFF);
    dir_smp(8'd250, 1'b0);
    dir_smp(8'd3, 1'b1);
    // A zero step closes a bin on every sample, so the last one releases two rows.
    dir_cfg(bpdh_pkg::REG_BIN_STEP, 16'd0);
    dir_smp(8'd9, 1'b0);
    dir_smp(8'd4, 1'b1);
    dir_cfg(bpdh_pkg::REG_BIN_STEP, 16'd128);
    dir_smp(8'd1, 1'b0);
    dir_smp(8'd3, 1'b1);
    // Row limit of one suppresses the final pixel, so no column end is marked.
    dir_cfg(bpdh_pkg::REG_BIN_STEP, 16'd256);
    dir_cfg(bpdh_pkg::REG_ROW_LIMIT, 16'd1);
    dir_smp(8'd50, 1'b0);
    dir_smp(8'd60, 1'b0);
    dir_smp(8'd70, 1'b1);
    dir_cfg(bpdh_pkg::REG_ROW_LIMIT, 16'd0);
    dir_smp(8'd80, 1'b0);
    dir_smp(8'd90, 1'b1);
    // Step changes in the middle of an open column.
    dir_cfg(bpdh_pkg::REG_ROW_LIMIT, 16'd255);
    dir_smp(8'd11, 1'b0);
    dir_smp(8'd12, 1'b0);
    dir_cfg(bpdh_pkg::REG_BIN_STEP, 16'd768);
    dir_smp(8'd13, 1'b0);
    dir_smp(8'd14, 1'b1);
    // Pass-through ignores the row limit.
    dir_cfg(bpdh_pkg::REG_ROW_LIMIT, 16'd0);
    dir_cfg(bpdh_pkg::REG_DECIMATE_ON, 16'd0);
    dir_smp(8'd33, 1'b1);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].idx, directed[i].val);
      else send_sample(directed[i].smp, directed[i].mark, directed[i].typed,
                       directed[i].want);
    end

    for (mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 33 : (mode == 1) ? 80 : 0;
      recv_idle = (mode == 0) ? 80 : (mode == 1) ? 33 : 0;
      for (ph = 0; ph < 4; ph++) begin
        phase_no = mode * 4 + ph;
        if (phase_no == 0) begin
          dec_val = 16'd1; step_val = 16'd256; limit_val = 16'd255; thresh_val = 16'd255;
        end else if (phase_no == 1) begin
          dec_val = 16'd1; step_val = 16'hFFFF; limit_val = 16'd1; thresh_val = 16'd1;
        end else begin
          dec_val = 16'($urandom_range(1));
          case ($urandom_range(9))
            0: step_val = 16'd256;
            1: step_val = 16'hFFFF;
            2: step_val = 16'($urandom_range(255));
            default: step_val = 16'($urandom_range(1536, 256));
          endcase
          case ($urandom_range(5))
            0: limit_val = 16'd1;
            1: limit_val = 16'd255;
            2: limit_val = 16'd0;
            default: limit_val = 16'($urandom_range(8, 1));
          endcase
          case ($urandom_range(5))
            0: thresh_val = 16'd0;
            1: thresh_val = 16'd255;
            2: thresh_val = 16'd1;
            default: thresh_val = 16'($urandom_range(255));
          endcase
        end
        write_reg(bpdh_pkg::REG_DECIMATE_ON, dec_val);
        write_reg(bpdh_pkg::REG_BIN_STEP, step_val);
        write_reg(bpdh_pkg::REG_ROW_LIMIT, limit_val);
        write_reg(bpdh_pkg::REG_THRESHOLD, thresh_val);

        // One column runs past the scan length without a mark.
        force_long = (phase_no == 8);
        n_items = force_long ? 300 : 48;
        for (k = 0; k < n_items; k++) begin
          if (phase_no == 2 && k == 24) begin
            s_tvalid <= 1'b0;
            while (pending_pixels.size() != 0) @(negedge clk);
            @(negedge clk);
          end
          if (col_left == 0) begin
            if (force_long) begin
              col_left = 300;
              col_marked = 1'b0;
              force_long = 1'b0;
            end else begin
              col_left = $urandom_range(24, 1);
              col_marked = ($urandom_range(15) != 0);
            end
          end
          case ($urandom_range(7))
            0: smp = 8'd0;
            1: smp = 8'd255;
            default: smp = 8'($urandom_range(255));
          endcase
          send_sample(smp, col_marked && col_left == 1, 1'b0, want_px);
          col_left--;
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
